[rtl/ldf_pkg.sv]
// Shared types and constants for the length-prefixed deframer.
`timescale 1ns / 1ps
`default_nettype none

package ldf_pkg;

  localparam int unsigned SizeWidth = 32;
  localparam logic [SizeWidth-1:0] HeaderBytes = 32'd4;
  localparam logic [SizeWidth-1:0] MaxSizeReset = 32'd65536;

  typedef struct packed {
    logic [7:0]           payload_byte;
    logic                 first_byte;
    logic                 last_byte;
    logic [SizeWidth-1:0] message_size;
  } ldf_result_t;

endpackage

`default_nettype wire

[rtl/length_prefixed_deframer.sv]
// Top level of the length-prefixed deframer: input register, framer and result buffer.
`timescale 1ns / 1ps
`default_nettype none

// The deframer takes one stream byte per cycle and keeps that rate indefinitely
// while the output side takes results. Each item is captured in an input register
// and processed by the framing logic once the result buffer has room. A payload
// byte is then written into the result buffer, from which it is presented at the
// output. Header bytes, discarded payload and restart items produce no result. A
// two-entry result buffer absorbs the output stall reaction, and in_stall_o is
// driven from registers only, so it rises only while the buffer is full and an
// item waits in the input register. The maximum message size register should be
// written while no message is in progress.
module length_prefixed_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        restart_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       payload_byte_o,
  output logic             first_byte_o,
  output logic             last_byte_o,
  output logic [31:0]      message_size_o
);
  import ldf_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_restart_q;
  logic        buf_full;
  logic        advance;
  logic        in_accept;
  logic        res_valid;
  ldf_result_t res;
  ldf_result_t out_data;

  // The held item moves into the framer whenever the result buffer has room.
  assign advance    = in_vld_q && !buf_full;
  assign in_stall_o = in_vld_q && buf_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q    <= data_byte_i;
      in_restart_q <= restart_i;
    end
  end

  ldf_framer u_framer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .item_valid_i   (advance),
    .item_byte_i    (in_byte_q),
    .item_restart_i (in_restart_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  ldf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign payload_byte_o = out_data.payload_byte;
  assign first_byte_o   = out_data.first_byte;
  assign last_byte_o    = out_data.last_byte;
  assign message_size_o = out_data.message_size;

endmodule

`default_nettype wire

[rtl/ldf_framer.sv]
// Framing state machine: header assembly, payload counting and discard of oversize messages.
`timescale 1ns / 1ps
`default_nettype none

module ldf_framer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ldf_pkg::SizeWidth-1:0] cfg_wdata_i,
  input  wire logic                        item_valid_i,
  input  wire logic [7:0]                  item_byte_i,
  input  wire logic                        item_restart_i,
  output logic                             res_valid_o,
  output ldf_pkg::ldf_result_t             res_o
);
  import ldf_pkg::*;

  logic [SizeWidth-1:0] max_size_q;
  logic [1:0]           hdr_cnt_q, hdr_cnt_d;
  logic [SizeWidth-1:0] len_acc_q, len_acc_d;
  logic [SizeWidth-1:0] remain_q, remain_d;
  logic                 discard_q, discard_d;
  logic                 first_q, first_d;

  logic [SizeWidth-1:0] acc_base;
  logic [SizeWidth-1:0] acc_new;
  logic [SizeWidth-1:0] remain_dec;

  always_comb begin
    acc_base = (hdr_cnt_q == 2'd0) ? '0 : len_acc_q;
    acc_new  = acc_base;
    case (hdr_cnt_q)
      2'd0:    acc_new[7:0]   = acc_base[7:0]   | item_byte_i;
      2'd1:    acc_new[15:8]  = acc_base[15:8]  | item_byte_i;
      2'd2:    acc_new[23:16] = acc_base[23:16] | item_byte_i;
      2'd3:    acc_new[31:24] = acc_base[31:24] | item_byte_i;
      default: acc_new        = acc_base;
    endcase
  end

  assign remain_dec = remain_q - 32'd1;

  always_comb begin
    hdr_cnt_d   = hdr_cnt_q;
    len_acc_d   = len_acc_q;
    remain_d    = remain_q;
    discard_d   = discard_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o.payload_byte = item_byte_i;
    res_o.first_byte   = first_q;
    res_o.last_byte    = (remain_dec == '0);
    res_o.message_size = len_acc_q;
    if (item_valid_i) begin
      if (item_restart_i) begin
        hdr_cnt_d = '0;
        len_acc_d = '0;
        remain_d  = '0;
        discard_d = 1'b0;
        first_d   = 1'b0;
      end else if (remain_q == '0) begin
        len_acc_d = acc_new;
        hdr_cnt_d = hdr_cnt_q + 2'd1;
        // The fourth header byte completes the length and decides the message's fate.
        if (hdr_cnt_q == 2'd3) begin
          if (acc_new <= HeaderBytes) begin
            remain_d  = '0;
            discard_d = 1'b0;
            first_d   = 1'b0;
          end else begin
            remain_d  = acc_new - HeaderBytes;
            discard_d = (acc_new > max_size_q);
            first_d   = 1'b1;
          end
        end
      end else begin
        remain_d = remain_dec;
        if (discard_q) begin
          if (remain_dec == '0) begin
            discard_d = 1'b0;
          end
        end else begin
          res_valid_o = 1'b1;
          first_d     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= MaxSizeReset;
      hdr_cnt_q  <= '0;
      len_acc_q  <= '0;
      remain_q   <= '0;
      discard_q  <= 1'b0;
      first_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_size_q <= cfg_wdata_i;
      end
      hdr_cnt_q <= hdr_cnt_d;
      len_acc_q <= len_acc_d;
      remain_q  <= remain_d;
      discard_q <= discard_d;
      first_q   <= first_d;
    end
  end

endmodule

`default_nettype wire

[rtl/ldf_out_buf.sv]
// Two-entry result buffer that decouples the output stall from the framing pipeline.
`timescale 1ns / 1ps
`default_nettype none

module ldf_out_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  ldf_pkg::ldf_result_t      push_data_i,
  output logic                      full_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ldf_pkg::ldf_result_t      out_data_o
);
  import ldf_pkg::*;

  ldf_result_t entry_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q;
  logic        pop;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire
